/* hdl/slb_pkg.sv */
package slb_pkg;

   localparam int unsigned ModeWidth  = 2;
   localparam int unsigned PhaseWidth = 11;
   localparam int unsigned HoldWidth  = 17;
   localparam int unsigned DebWidth   = 10;
   localparam int unsigned HoldMsWidth = 16;

   typedef logic [ModeWidth-1:0]   mode_type;
   typedef logic [PhaseWidth-1:0]  phase_type;
   typedef logic [HoldWidth-1:0]   hold_count_type;

   localparam mode_type MODE_WAIT = 2'd0;
   localparam mode_type MODE_FIX  = 2'd1;
   localparam mode_type MODE_REC  = 2'd2;
   localparam mode_type MODE_SHUT = 2'd3;

   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_HOLD     = 1'b1;

   localparam phase_type LONG_PERIOD  = 11'd1500;
   localparam phase_type BURST_PERIOD = 11'd325;
   localparam phase_type REC_PERIOD   = 11'd1;

   localparam logic [DebWidth-1:0]    DEBOUNCE_RESET = 10'd200;
   localparam logic [HoldMsWidth-1:0] HOLD_RESET     = 16'd3000;
   localparam hold_count_type         HOLD_MAX       = 17'h1_FFFF;

   function automatic phase_type period_of(input mode_type mode);
      phase_type per;
      case (mode)
         MODE_REC:  per = REC_PERIOD;
         MODE_SHUT: per = BURST_PERIOD;
         default:   per = LONG_PERIOD;
      endcase
      return per;
   endfunction

   function automatic logic level_of(input mode_type mode, input phase_type p);
      logic lvl;
      case (mode)
         MODE_WAIT: lvl = (p < 11'd250);
         MODE_FIX:  lvl = (p < 11'd250) || ((p >= 11'd500) && (p < 11'd750));
         MODE_REC:  lvl = 1'b1;
         default: begin
            // shutdown burst: four equal flashes, with a shorter gap between the second and third
            if (p < 11'd50)       lvl = 1'b1;
            else if (p < 11'd100) lvl = 1'b0;
            else if (p < 11'd150) lvl = 1'b1;
            else if (p < 11'd175) lvl = 1'b0;
            else if (p < 11'd225) lvl = 1'b1;
            else if (p < 11'd275) lvl = 1'b0;
            else                  lvl = 1'b1;
         end
      endcase
      return lvl;
   endfunction

endpackage

/* hdl/slb_pattern.sv */
module slb_pattern (
   input  slb_pkg::mode_type  mode,
   input  slb_pkg::phase_type phase,
   output logic               level,
   output slb_pkg::phase_type phase_next
);
   import slb_pkg::*;

   phase_type per;
   phase_type p;
   phase_type p_inc;

   always_comb begin
      per = period_of(mode);
      // wrap a stale phase before looking up the level
      p = (phase >= per) ? '0 : phase;
      level = level_of(mode, p);
      p_inc = p + 11'd1;
      phase_next = (p_inc >= per) ? '0 : p_inc;
   end

endmodule

/* hdl/status_led_blinker_with_hold_off_unit.sv */
// Result: a tick's result is registered and shows on rsp_tdata in the cycle after the tick is accepted.
// Throughput: one tick per cycle; the result register frees as soon as it is taken,
// and req_tready drops only while a result waits and rsp_tready is low.
// Reset: synchronous, active high; clears mode, hold, phase, LED, halt and power-off
// state and restores debounce_ms to 200 and hold_ms to 3000.
module status_led_blinker_with_hold_off_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] button_pressed, [1] mode_valid, [3:2] new_mode, [4] halt_request
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] led_on, [1] power_off, [3:2] shown_mode, [4] is_halted
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import slb_pkg::*;

   logic [DebWidth-1:0]    debounce_ff;
   logic [HoldMsWidth-1:0] hold_ms_ff;

   mode_type       cur_mode_ff, cur_mode_in;
   mode_type       saved_mode_ff, saved_mode_in;
   logic           held_ff, held_in;
   hold_count_type hold_count_ff, hold_count_in;
   phase_type      phase_ff, phase_in;
   logic           led_ff, led_in;
   logic           halted_ff, halted_in;
   logic           off_ff, off_in;

   logic           rsp_valid_ff;
   logic [7:0]     rsp_data_ff;

   logic           accept;
   logic           btn, mval, hreq;
   mode_type       nmode;
   mode_type       mode_req;
   hold_count_type threshold;
   phase_type      phase_base;
   logic           pat_level;
   phase_type      pat_phase_next;

   assign btn   = req_tdata[0];
   assign mval  = req_tdata[1];
   assign nmode = req_tdata[3:2];
   assign hreq  = req_tdata[4];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign threshold = {7'd0, debounce_ff} + {1'b0, hold_ms_ff};

   always_comb begin
      mode_req      = mval ? nmode : cur_mode_ff;
      cur_mode_in   = mode_req;
      saved_mode_in = saved_mode_ff;
      held_in       = held_ff;
      hold_count_in = hold_count_ff;
      off_in        = off_ff;
      halted_in     = halted_ff;

      if (btn) begin
         if (!held_ff) begin
            saved_mode_in = mode_req;
            cur_mode_in   = MODE_SHUT;
            held_in       = 1'b1;
            hold_count_in = '0;
         end else if (hold_count_ff != HOLD_MAX) begin
            hold_count_in = hold_count_ff + 17'd1;
         end
         if (hold_count_in >= threshold) begin
            off_in    = 1'b1;
            halted_in = 1'b1;
         end
      end else if (held_ff) begin
         cur_mode_in = saved_mode_ff;
         held_in     = 1'b0;
      end

      // restart the pattern on any real mode change
      phase_base = (cur_mode_in != cur_mode_ff) ? '0 : phase_ff;

      if (hreq) halted_in = 1'b1;
   end

   slb_pattern u_pattern (
      .mode       (cur_mode_in),
      .phase      (phase_base),
      .level      (pat_level),
      .phase_next (pat_phase_next)
   );

   always_comb begin
      led_in   = led_ff;
      phase_in = phase_base;
      if (off_in) begin
         led_in = 1'b0;
      end else if (!halted_in) begin
         led_in   = pat_level;
         phase_in = pat_phase_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         hold_ms_ff  <= HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_data[DebWidth-1:0];
            CSR_HOLD:     hold_ms_ff  <= csr_data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff   <= MODE_WAIT;
         saved_mode_ff <= MODE_WAIT;
         held_ff       <= 1'b0;
         hold_count_ff <= '0;
         phase_ff      <= '0;
         led_ff        <= 1'b0;
         halted_ff     <= 1'b0;
         off_ff        <= 1'b0;
      end else if (accept) begin
         cur_mode_ff   <= cur_mode_in;
         saved_mode_ff <= saved_mode_in;
         held_ff       <= held_in;
         hold_count_ff <= hold_count_in;
         phase_ff      <= phase_in;
         led_ff        <= led_in;
         halted_ff     <= halted_in;
         off_ff        <= off_in;
      end
   end

   // result register: load on every accepted tick, drop once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {3'd0, halted_in, cur_mode_in, off_in, led_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/slb_checker.sv */
module slb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import slb_pkg::*;

   // power-off forces the LED dark and reports halted
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0] && rsp_tdata[4])
      else $error("power_off shown with LED lit or not halted");

   // recording mode keeps the LED on unless halted
   a_rec_on: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:2] == MODE_REC) && !rsp_tdata[4] |-> rsp_tdata[0])
      else $error("recording mode without steady LED");

   // every accepted tick produces a result next cycle
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick produced no result");

   // a waiting result blocks new ticks
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("tick accepted while result stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind status_led_blinker_with_hold_off_unit slb_checker u_slb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* verif/status_led_blinker_with_hold_off_unit_tb.sv */
`timescale 1ns / 100ps

module status_led_blinker_with_hold_off_unit_tb;
   import slb_pkg::*;

   localparam int CycleLimit = 500_000;

   // one millisecond tick as it travels on req_tdata, button in bit 0
   typedef struct packed {
      logic     halt;
      mode_type new_mode;
      logic     mode_valid;
      logic     button;
   } tick_type;

   // LED status as it travels on rsp_tdata, led_on in bit 0
   typedef struct packed {
      logic     halted;
      mode_type shown;
      logic     power_off;
      logic     led;
   } led_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_DEBOUNCE;
   logic [15:0] csr_data = 16'h0000;

   status_led_blinker_with_hold_off_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   tick_type       pending_ticks[$];
   led_status_type expected_status[$];

   int  queued_total = 0;
   int  ticks_sent = 0;
   int  results_seen = 0;
   int  led_on_count = 0;
   int  power_off_count = 0;
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  req_taken = 1'b0;
   bit  hold_off = 1'b0;
   bit  send_calm = 1'b0;
   bit  recv_calm = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;

   // blinker state mirror
   mode_type            mode_now = MODE_WAIT;
   mode_type            mode_saved = MODE_WAIT;
   logic                btn_held = 1'b0;
   hold_count_type      held_ticks = '0;
   phase_type           phase = '0;
   logic                led_q = 1'b0;
   logic                halt_q = 1'b0;
   logic                off_q = 1'b0;
   logic [9:0]          deb_cfg = 10'd200;
   logic [15:0]         hold_cfg = 16'd3000;

   function automatic logic blink_level(input mode_type m, input phase_type p);
      case (m)
         MODE_WAIT: return p < 250;
         MODE_FIX:  return (p < 250) || (p >= 500 && p < 750);
         MODE_REC:  return 1'b1;
         default:   return (p < 50) || (p >= 100 && p < 150) || (p >= 175 && p < 225)
                           || (p >= 275);
      endcase
   endfunction

   function automatic led_status_type next_led_status(input tick_type t);
      mode_type       prior;
      int             burst_len;
      led_status_type s;
      prior = mode_now;
      if (t.mode_valid) mode_now = t.new_mode;
      if (t.button) begin
         if (!btn_held) begin
            mode_saved = mode_now;
            mode_now = MODE_SHUT;
            btn_held = 1'b1;
            held_ticks = '0;
         end else if (held_ticks != HOLD_MAX) begin
            held_ticks = held_ticks + 1'b1;
         end
         if (int'(held_ticks) >= int'(deb_cfg) + int'(hold_cfg)) begin
            off_q = 1'b1;
            halt_q = 1'b1;
         end
      end else if (btn_held) begin
         mode_now = mode_saved;
         btn_held = 1'b0;
      end
      if (mode_now != prior) phase = '0;
      if (t.halt) halt_q = 1'b1;
      if (off_q) begin
         led_q = 1'b0;
      end else if (!halt_q) begin
         case (mode_now)
            MODE_REC:  burst_len = 1;
            MODE_SHUT: burst_len = 325;
            default:   burst_len = 1500;
         endcase
         if (phase >= burst_len) phase = '0;
         led_q = blink_level(mode_now, phase);
         phase = phase + 1'b1;
         if (phase >= burst_len) phase = '0;
      end
      s.led = led_q;
      s.power_off = off_q;
      s.shown = mode_now;
      s.halted = halt_q;
      return s;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   task automatic push_tick(input logic btn, input logic mval, input mode_type m,
                            input logic halt);
      tick_type t;
      t.button = btn;
      t.mode_valid = mval;
      t.new_mode = m;
      t.halt = halt;
      pending_ticks.push_back(t);
      queued_total++;
   endtask

   // well-formed episodes: quiet runs, mode requests, presses held up to the threshold
   task automatic queue_random_ticks(input int n_items, input int thr);
      int goal;
      int kind;
      int len;
      int r;
      goal = queued_total + n_items;
      while (queued_total < goal) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            r = $urandom_range(0, 9);
            if (r < 6) len = $urandom_range(1, 10);
            else if (r < 9) len = $urandom_range(11, 80);
            else len = $urandom_range(150, 600);
            repeat (len) push_tick(1'b0, 1'b0, mode_type'($urandom_range(0, 3)), 1'b0);
         end else if (kind <= 5) begin
            push_tick(1'b0, 1'b1, mode_type'($urandom_range(0, 3)), 1'b0);
         end else if (kind <= 8) begin
            r = $urandom_range(0, 9);
            if (r < 7) len = $urandom_range(1, 20);
            else if (r < 9) len = $urandom_range(21, 300);
            else len = (thr > 400) ? $urandom_range(300, 400) : thr;
            if (len > thr) len = thr;
            push_tick(1'b1, $urandom_range(0, 7) == 0, mode_type'($urandom_range(0, 3)), 1'b0);
            repeat (len - 1)
               push_tick(1'b1, $urandom_range(0, 15) == 0, mode_type'($urandom_range(0, 3)),
                         1'b0);
            push_tick(1'b0, $urandom_range(0, 5) == 0, mode_type'($urandom_range(0, 3)), 1'b0);
         end else begin
            push_tick(1'b0, 1'($urandom_range(0, 1)), mode_type'($urandom_range(0, 3)), 1'b0);
         end
      end
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_DEBOUNCE) deb_cfg = value[9:0];
      else hold_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender: hold the item until the transfer, then wait out the gap
   always @(negedge clock) begin : drive_ticks
      tick_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            nxt = pending_ticks.pop_front();
            req_tdata <= {3'b000, nxt};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus the long hold-off
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
         if (!recv_calm && $urandom_range(0, 2) == 0) stall_left = pick_gap(1'b0);
      end
   end

   always @(posedge clock) begin : check_results
      led_status_type got;
      led_status_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = led_status_type'(rsp_tdata[4:0]);
            results_seen++;
            if (got.led) led_on_count++;
            if (got.power_off) power_off_count++;
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               compare_field("led_on", want.led, got.led);
               compare_field("power_off", want.power_off, got.power_off);
               compare_field("shown_mode", want.shown, got.shown);
               compare_field("is_halted", want.halted, got.halted);
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            ticks_sent++;
            expected_status.push_back(next_led_status(tick_type'(req_tdata[4:0])));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_status.size());
         $display("FAILURE");
         $finish;
      end
   end

   // stall the result side long enough that the input backs up
   initial begin
      wait (!reset);
      wait (results_seen >= 60);
      hold_off = 1'b1;
      repeat (80) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      int          hold_val;
      logic [9:0]  deb_val;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // mode requests, same-mode rewrite, presses with requests on press, hold and release
      push_tick(1'b0, 1'b0, MODE_WAIT, 1'b0);
      push_tick(1'b0, 1'b0, MODE_SHUT, 1'b0);
      push_tick(1'b0, 1'b1, MODE_FIX, 1'b0);
      push_tick(1'b0, 1'b1, MODE_FIX, 1'b0);
      push_tick(1'b0, 1'b0, MODE_WAIT, 1'b0);
      push_tick(1'b0, 1'b1, MODE_REC, 1'b0);
      push_tick(1'b0, 1'b1, MODE_SHUT, 1'b0);
      push_tick(1'b0, 1'b0, MODE_REC, 1'b0);
      push_tick(1'b0, 1'b1, MODE_WAIT, 1'b0);
      push_tick(1'b1, 1'b0, MODE_WAIT, 1'b0);
      push_tick(1'b1, 1'b1, MODE_FIX, 1'b0);
      push_tick(1'b1, 1'b0, MODE_WAIT, 1'b0);
      push_tick(1'b0, 1'b0, MODE_WAIT, 1'b0);
      push_tick(1'b1, 1'b1, MODE_REC, 1'b0);
      push_tick(1'b1, 1'b0, MODE_REC, 1'b0);
      push_tick(1'b0, 1'b1, MODE_FIX, 1'b0);
      push_tick(1'b1, 1'b1, MODE_SHUT, 1'b0);
      push_tick(1'b0, 1'b0, MODE_SHUT, 1'b0);
      push_tick(1'b0, 1'b0, MODE_SHUT, 1'b0);
      push_tick(1'b0, 1'b1, MODE_FIX, 1'b0);
      queue_random_ticks(300, int'(deb_cfg) + int'(hold_cfg));
      wait_until_drained();

      // largest thresholds; the debounce write also sets the unused upper bits
      write_csr(CSR_DEBOUNCE, 16'hFFFF);
      write_csr(CSR_HOLD, 16'hFFFF);
      queue_random_ticks(300, int'(deb_cfg) + int'(hold_cfg));
      wait_until_drained();

      // small thresholds so that presses reach just short of power-off
      repeat (2) begin
         deb_val = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'($urandom_range(1, 40));
         hold_val = $urandom_range(0, 60);
         if (deb_val == 0 && hold_val == 0) hold_val = 1;
         write_csr(CSR_DEBOUNCE, {6'($urandom), deb_val});
         write_csr(CSR_HOLD, 16'(hold_val));
         queue_random_ticks(150, int'(deb_cfg) + int'(hold_cfg));
         wait_until_drained();
      end

      // zero thresholds: halt first, then a press that latches power-off at once
      write_csr(CSR_DEBOUNCE, {6'($urandom), 10'd0});
      write_csr(CSR_HOLD, 16'd0);
      repeat (40) push_tick(1'b0, 1'($urandom_range(0, 1)), mode_type'($urandom_range(0, 3)),
                            1'b0);
      push_tick(1'b0, 1'b0, MODE_WAIT, 1'b1);
      repeat (30) push_tick(1'b0, 1'($urandom_range(0, 1)), mode_type'($urandom_range(0, 3)),
                            1'b0);
      push_tick(1'b1, 1'b0, MODE_FIX, 1'b0);
      repeat (20) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            mode_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      wait_until_drained();
      repeat (10) @(posedge clock);

      $display("Sent %0d ticks over five threshold settings; checked %0d results", ticks_sent,
               results_seen);
      $display("LED on in %0d results, power-off latched in %0d, %0d mismatches",
               led_on_count, power_off_count, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/slb_pkg.sv
hdl/slb_pattern.sv
hdl/status_led_blinker_with_hold_off_unit.sv
hdl/slb_checker.sv
verif/status_led_blinker_with_hold_off_unit_tb.sv
